@@ hw/rtl/mma_pkg.sv @@
// Shared types and constants for the Montgomery modular ALU.
// Used by the controller, the datapath and the top level.
`default_nettype none
package mma_pkg;

    localparam int WORD_W = 64;
    localparam int MOD_W  = 62;
    localparam int VAL_W  = 63;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        CFG_MODULUS   = 2'd0,
        CFG_NEG_INV   = 2'd1,
        CFG_R_SQUARED = 2'd2
    } cfg_reg_t;

    typedef enum logic [3:0] {
        CMD_CONV_IN  = 4'd0,
        CMD_CONV_OUT = 4'd1,
        CMD_ADD      = 4'd2,
        CMD_SUB      = 4'd3,
        CMD_MUL      = 4'd4,
        CMD_POW      = 4'd5,
        CMD_INV      = 4'd6,
        CMD_DIV      = 4'd7,
        CMD_NEG      = 4'd8
    } cmd_t;

    typedef enum logic [4:0] {
        DP_IDLE,
        DP_CAPTURE,
        DP_ADD,
        DP_SUB,
        DP_NEG,
        DP_CLEAR,
        DP_DIV_INT,
        DP_DIV_ONE,
        DP_DIV_EXP,
        DP_DIV_INV,
        DP_EXP_SET,
        DP_EXP_SHIFT,
        DP_MM_CI,
        DP_MM_OUT,
        DP_MM_AB,
        DP_MM_PB,
        DP_MM_BB,
        DP_MM_AP,
        DP_MUL_T,
        DP_MUL_Q,
        DP_MUL_P,
        DP_REDC_FIN,
        DP_POW_BASE_A,
        DP_POW_BASE_B,
        DP_PROD_FROM_R,
        DP_BASE_FROM_R,
        DP_RES_FROM_R,
        DP_RES_FROM_PROD,
        DP_RES_OUT,
        DP_PUBLISH
    } dp_op_t;

    typedef struct packed {
        logic mul_busy;
        logic div_busy;
        logic int_zero;
        logic e_zero;
        logic e_lsb;
    } dp_status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_CI_WAIT,
        S_PW_EXP,
        S_PW_EWAIT,
        S_PW_ODIV,
        S_PW_OWAIT,
        S_PW_ONE,
        S_PW_LOOP,
        S_PW_MULD,
        S_PW_SQ,
        S_PW_SQC,
        S_PW_SQD,
        S_MM_T,
        S_MM_TW,
        S_MM_QW,
        S_MM_PW,
        S_RES_R,
        S_OUT_FIN,
        S_DONE
    } ctrl_state_t;

endpackage
`default_nettype wire

@@ hw/rtl/mma_mul.sv @@
// Iterative 64x64 -> 128 bit multiplier built on one 32x32 multiplier.
// Four partial products, registered, then accumulated; depends on mma_pkg.
`default_nettype none
module mma_mul (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [mma_pkg::WORD_W-1:0]      x,
    input  wire logic [mma_pkg::WORD_W-1:0]      y,
    output logic                                 busy,
    output logic [2*mma_pkg::WORD_W-1:0]         acc
);
    import mma_pkg::*;

    localparam int HALF_W = WORD_W / 2;

    logic [WORD_W-1:0]   x_reg;
    logic [WORD_W-1:0]   y_reg;
    logic [WORD_W-1:0]   p_reg;
    logic [1:0]          sh_reg;
    logic [2*WORD_W-1:0] acc_reg;
    logic [2:0]          cnt_reg;
    logic                busy_reg;

    logic [HALF_W-1:0]   px;
    logic [HALF_W-1:0]   py;
    logic [1:0]          part_sh;
    logic [WORD_W-1:0]   part;
    logic [2*WORD_W-1:0] shifted;

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:
            begin
                px = x_reg[HALF_W-1:0];
                py = y_reg[HALF_W-1:0];
                part_sh = 2'd0;
            end
            2'd1:
            begin
                px = x_reg[HALF_W-1:0];
                py = y_reg[WORD_W-1:HALF_W];
                part_sh = 2'd1;
            end
            2'd2:
            begin
                px = x_reg[WORD_W-1:HALF_W];
                py = y_reg[HALF_W-1:0];
                part_sh = 2'd1;
            end
            default:
            begin
                px = x_reg[WORD_W-1:HALF_W];
                py = y_reg[WORD_W-1:HALF_W];
                part_sh = 2'd2;
            end
        endcase
        part = WORD_W'(px) * WORD_W'(py);
    end

    always_comb
    begin
        case (sh_reg)
            2'd1:    shifted = {{HALF_W{1'b0}}, p_reg, {HALF_W{1'b0}}};
            2'd2:    shifted = {p_reg, {WORD_W{1'b0}}};
            default: shifted = {{WORD_W{1'b0}}, p_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 3'd0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 3'd1;
            if (cnt_reg == 3'd4)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= x;
            y_reg   <= y;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != 3'd0)
                acc_reg <= acc_reg + shifted;
            if (cnt_reg != 3'd4)
            begin
                p_reg  <= part;
                sh_reg <= part_sh;
            end
        end
    end

    assign busy = busy_reg;
    assign acc  = acc_reg;

endmodule
`default_nettype wire

@@ hw/rtl/mma_div.sv @@
// Bit-serial signed remainder unit, truncating toward zero, one bit a cycle.
// Depends on mma_pkg.
`default_nettype none
module mma_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [mma_pkg::WORD_W-1:0]  dividend,
    input  wire logic [mma_pkg::WORD_W-1:0]  divisor,
    output logic                             busy,
    output logic [mma_pkg::WORD_W-1:0]       remainder
);
    import mma_pkg::*;

    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] dvd_reg;
    logic [WORD_W-1:0] dvs_reg;
    logic              neg_reg;
    logic [5:0]        cnt_reg;
    logic              busy_reg;

    logic [WORD_W-1:0] trial;
    logic [WORD_W-1:0] mag;

    assign trial = {rem_reg[WORD_W-2:0], dvd_reg[WORD_W-1]};
    assign mag   = dividend[WORD_W-1] ? (~dividend + WORD_W'(1)) : dividend;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= mag;
            dvs_reg <= divisor;
            neg_reg <= dividend[WORD_W-1];
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[WORD_W-2:0], 1'b0};
            if (trial >= dvs_reg)
                rem_reg <= trial - dvs_reg;
            else
                rem_reg <= trial;
        end
    end

    assign busy      = busy_reg;
    assign remainder = neg_reg ? (~rem_reg + WORD_W'(1)) : rem_reg;

endmodule
`default_nettype wire

@@ hw/rtl/mma_dp.sv @@
// Datapath: configuration registers, operand and working registers,
// Montgomery reduction, modular add/sub/neg; uses mma_mul, mma_div, mma_pkg.
`default_nettype none
module mma_dp (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire mma_pkg::dp_op_t                op,
    output mma_pkg::dp_status_t                 status,
    input  wire logic                           cfg_write,
    input  wire logic [mma_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mma_pkg::WORD_W-1:0]     cfg_data,
    input  wire logic [mma_pkg::VAL_W-1:0]      operand_a,
    input  wire logic [mma_pkg::VAL_W-1:0]      operand_b,
    input  wire logic signed [mma_pkg::WORD_W-1:0] integer_in,
    input  wire logic signed [mma_pkg::WORD_W-1:0] exponent,
    output logic [mma_pkg::VAL_W-1:0]           result
);
    import mma_pkg::*;

    logic [MOD_W-1:0]  m_reg;
    logic [WORD_W-1:0] ninv_reg;
    logic [MOD_W-1:0]  r2_reg;

    logic [VAL_W-1:0]  a_reg;
    logic [VAL_W-1:0]  b_reg;
    logic [WORD_W-1:0] int_reg;
    logic [WORD_W-1:0] exp_reg;
    logic [WORD_W-1:0] ci_raw_reg;
    logic [WORD_W-1:0] e_reg;
    logic [WORD_W-1:0] base_reg;
    logic [WORD_W-1:0] prod_reg;
    logic [WORD_W-1:0] mm_x_reg;
    logic [WORD_W-1:0] mm_y_reg;
    logic [WORD_W-1:0] t_hi_reg;
    logic [WORD_W-1:0] t_lo_reg;
    logic [WORD_W-1:0] mm_r_reg;
    logic [WORD_W-1:0] res_reg;
    logic [VAL_W-1:0]  out_reg;

    logic [WORD_W-1:0]   m_ext;
    logic [WORD_W-1:0]   two_m;
    logic [WORD_W-1:0]   a_ext;
    logic [WORD_W-1:0]   b_ext;
    logic [WORD_W-1:0]   add_v;
    logic [WORD_W-1:0]   sub_v;
    logic [WORD_W-1:0]   neg_v;
    logic [WORD_W-1:0]   ci_base;
    logic [WORD_W-1:0]   exp_red;
    logic [WORD_W:0]     lo_sum;
    logic [WORD_W-1:0]   redc_v;
    logic [WORD_W-1:0]   out_v;

    logic                mul_start;
    logic [WORD_W-1:0]   mul_x;
    logic [WORD_W-1:0]   mul_y;
    logic                mul_busy;
    logic [2*WORD_W-1:0] mul_acc;

    logic                div_start;
    logic [WORD_W-1:0]   div_dvd;
    logic [WORD_W-1:0]   div_dvs;
    logic                div_busy;
    logic [WORD_W-1:0]   div_rem;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg    <= MOD_W'(3);
            ninv_reg <= '0;
            r2_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_MODULUS:   m_reg    <= cfg_data[MOD_W-1:0];
                CFG_NEG_INV:   ninv_reg <= cfg_data;
                CFG_R_SQUARED: r2_reg   <= cfg_data[MOD_W-1:0];
                default:       ;
            endcase
        end
    end

    assign m_ext = WORD_W'(m_reg);
    assign two_m = {m_ext[WORD_W-2:0], 1'b0};
    assign a_ext = WORD_W'(a_reg);
    assign b_ext = WORD_W'(b_reg);

    always_comb
    begin
        add_v = a_ext + b_ext - two_m;
        if (add_v[WORD_W-1])
            add_v = add_v + two_m;
        sub_v = a_ext - b_ext;
        if (sub_v[WORD_W-1])
            sub_v = sub_v + two_m;
        neg_v = '0 - a_ext;
        if (neg_v[WORD_W-1])
            neg_v = neg_v + two_m;
    end

    // zero modulus takes the raw pattern unchanged
    assign ci_base = (m_reg == '0) ? ci_raw_reg : div_rem + m_ext;

    always_comb
    begin
        exp_red = '0;
        if (m_reg > MOD_W'(1))
        begin
            exp_red = div_rem;
            if (div_rem[WORD_W-1])
                exp_red = div_rem + m_ext - WORD_W'(1);
        end
    end

    assign lo_sum = {1'b0, t_lo_reg} + {1'b0, mul_acc[WORD_W-1:0]};
    assign redc_v = t_hi_reg + mul_acc[2*WORD_W-1:WORD_W] + WORD_W'(lo_sum[WORD_W]);
    assign out_v  = (mm_r_reg >= m_ext) ? mm_r_reg - m_ext : mm_r_reg;

    always_comb
    begin
        mul_start = 1'b0;
        mul_x     = mm_x_reg;
        mul_y     = mm_y_reg;
        case (op)
            DP_MUL_T: mul_start = 1'b1;
            DP_MUL_Q:
            begin
                mul_start = 1'b1;
                mul_x     = mul_acc[WORD_W-1:0];
                mul_y     = ninv_reg;
            end
            DP_MUL_P:
            begin
                mul_start = 1'b1;
                mul_x     = mul_acc[WORD_W-1:0];
                mul_y     = m_ext;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        div_start = 1'b0;
        div_dvd   = int_reg;
        div_dvs   = m_ext;
        case (op)
            DP_DIV_INT: div_start = 1'b1;
            DP_DIV_ONE:
            begin
                div_start = 1'b1;
                div_dvd   = WORD_W'(1);
            end
            DP_DIV_EXP:
            begin
                div_start = 1'b1;
                div_dvd   = exp_reg;
                div_dvs   = m_ext - WORD_W'(1);
            end
            DP_DIV_INV:
            begin
                div_start = 1'b1;
                div_dvd   = '1;
                div_dvs   = m_ext - WORD_W'(1);
            end
            default: ;
        endcase
    end

    mma_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .x     (mul_x),
        .y     (mul_y),
        .busy  (mul_busy),
        .acc   (mul_acc)
    );

    mma_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .busy      (div_busy),
        .remainder (div_rem)
    );

    always_ff @(posedge clk)
    begin
        case (op)
            DP_CAPTURE:
            begin
                a_reg   <= operand_a;
                b_reg   <= operand_b;
                int_reg <= integer_in;
                exp_reg <= exponent;
            end
            DP_ADD:           res_reg <= add_v;
            DP_SUB:           res_reg <= sub_v;
            DP_NEG:           res_reg <= neg_v;
            DP_CLEAR:         res_reg <= '0;
            DP_DIV_INT:       ci_raw_reg <= int_reg;
            DP_DIV_ONE:       ci_raw_reg <= WORD_W'(1);
            DP_EXP_SET:       e_reg <= exp_red;
            DP_EXP_SHIFT:     e_reg <= {1'b0, e_reg[WORD_W-1:1]};
            DP_MM_CI:
            begin
                mm_x_reg <= ci_base;
                mm_y_reg <= WORD_W'(r2_reg);
            end
            DP_MM_OUT:
            begin
                mm_x_reg <= a_ext;
                mm_y_reg <= WORD_W'(1);
            end
            DP_MM_AB:
            begin
                mm_x_reg <= a_ext;
                mm_y_reg <= b_ext;
            end
            DP_MM_PB:
            begin
                mm_x_reg <= prod_reg;
                mm_y_reg <= base_reg;
            end
            DP_MM_BB:
            begin
                mm_x_reg <= base_reg;
                mm_y_reg <= base_reg;
            end
            DP_MM_AP:
            begin
                mm_x_reg <= a_ext;
                mm_y_reg <= prod_reg;
            end
            DP_MUL_Q:
            begin
                t_hi_reg <= mul_acc[2*WORD_W-1:WORD_W];
                t_lo_reg <= mul_acc[WORD_W-1:0];
            end
            DP_REDC_FIN:      mm_r_reg <= redc_v;
            DP_POW_BASE_A:    base_reg <= a_ext;
            DP_POW_BASE_B:    base_reg <= b_ext;
            DP_PROD_FROM_R:   prod_reg <= mm_r_reg;
            DP_BASE_FROM_R:   base_reg <= mm_r_reg;
            DP_RES_FROM_R:    res_reg <= mm_r_reg;
            DP_RES_FROM_PROD: res_reg <= prod_reg;
            DP_RES_OUT:       res_reg <= out_v;
            DP_PUBLISH:       out_reg <= res_reg[VAL_W-1:0];
            default: ;
        endcase
    end

    assign status.mul_busy = mul_busy;
    assign status.div_busy = div_busy;
    assign status.int_zero = (int_reg == '0);
    assign status.e_zero   = (e_reg == '0);
    assign status.e_lsb    = e_reg[0];
    assign result          = out_reg;

endmodule
`default_nettype wire

@@ hw/rtl/mma_ctrl.sv @@
// Controller state machine: sequences commands, Montgomery multiplies and
// the square-and-multiply loop; drives dp_op_t commands, uses mma_pkg.
`default_nettype none
module mma_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [3:0]           cmd,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    input  wire mma_pkg::dp_status_t  status,
    output mma_pkg::dp_op_t           op
);
    import mma_pkg::*;

    ctrl_state_t state_reg, state_next;
    ctrl_state_t ret_reg, ret_next;
    logic [3:0]  cmd_reg, cmd_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            cmd_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            cmd_reg       <= cmd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_DISPATCH;
            S_DISPATCH:
            begin
                case (cmd_t'(cmd_reg))
                    CMD_CONV_IN:  state_next = status.int_zero ? S_DONE : S_CI_WAIT;
                    CMD_CONV_OUT: state_next = S_MM_T;
                    CMD_MUL:      state_next = S_MM_T;
                    CMD_POW:      state_next = S_PW_EXP;
                    CMD_INV:      state_next = S_PW_EXP;
                    CMD_DIV:      state_next = S_PW_EXP;
                    default:      state_next = S_DONE;
                endcase
            end
            S_CI_WAIT:
                if (!status.div_busy)
                    state_next = S_MM_T;
            S_PW_EXP:   state_next = S_PW_EWAIT;
            S_PW_EWAIT:
                if (!status.div_busy)
                    state_next = S_PW_ODIV;
            S_PW_ODIV:  state_next = S_PW_OWAIT;
            S_PW_OWAIT:
                if (!status.div_busy)
                    state_next = S_MM_T;
            S_PW_ONE:   state_next = S_PW_LOOP;
            S_PW_LOOP:
            begin
                if (status.e_zero)
                    state_next = (cmd_t'(cmd_reg) == CMD_DIV) ? S_MM_T : S_DONE;
                else if (status.e_lsb)
                    state_next = S_MM_T;
                else
                    state_next = S_PW_SQ;
            end
            S_PW_MULD:  state_next = S_PW_SQ;
            S_PW_SQ:    state_next = S_PW_SQC;
            S_PW_SQC:   state_next = status.e_zero ? S_PW_LOOP : S_MM_T;
            S_PW_SQD:   state_next = S_PW_LOOP;
            S_MM_T:     state_next = S_MM_TW;
            S_MM_TW:
                if (!status.mul_busy)
                    state_next = S_MM_QW;
            S_MM_QW:
                if (!status.mul_busy)
                    state_next = S_MM_PW;
            S_MM_PW:
                if (!status.mul_busy)
                    state_next = ret_reg;
            S_RES_R:    state_next = S_DONE;
            S_OUT_FIN:  state_next = S_DONE;
            S_DONE:
                if (!out_valid_reg || !out_stall)
                    state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        op             = DP_IDLE;
        ret_next       = ret_reg;
        cmd_next       = cmd_reg;
        out_valid_next = out_valid_reg && out_stall;
        in_stall       = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    op       = DP_CAPTURE;
                    cmd_next = cmd;
                end
            S_DISPATCH:
            begin
                case (cmd_t'(cmd_reg))
                    CMD_CONV_IN:  op = status.int_zero ? DP_CLEAR : DP_DIV_INT;
                    CMD_CONV_OUT:
                    begin
                        op       = DP_MM_OUT;
                        ret_next = S_OUT_FIN;
                    end
                    CMD_ADD:      op = DP_ADD;
                    CMD_SUB:      op = DP_SUB;
                    CMD_NEG:      op = DP_NEG;
                    CMD_MUL:
                    begin
                        op       = DP_MM_AB;
                        ret_next = S_RES_R;
                    end
                    CMD_POW:      op = DP_POW_BASE_A;
                    CMD_INV:      op = DP_POW_BASE_A;
                    CMD_DIV:      op = DP_POW_BASE_B;
                    default:      op = DP_CLEAR;
                endcase
            end
            S_CI_WAIT:
                if (!status.div_busy)
                begin
                    op       = DP_MM_CI;
                    ret_next = S_RES_R;
                end
            S_PW_EXP:
                op = (cmd_t'(cmd_reg) == CMD_POW) ? DP_DIV_EXP : DP_DIV_INV;
            S_PW_EWAIT:
                if (!status.div_busy)
                    op = DP_EXP_SET;
            S_PW_ODIV:  op = DP_DIV_ONE;
            S_PW_OWAIT:
                if (!status.div_busy)
                begin
                    op       = DP_MM_CI;
                    ret_next = S_PW_ONE;
                end
            S_PW_ONE:   op = DP_PROD_FROM_R;
            S_PW_LOOP:
            begin
                if (status.e_zero)
                begin
                    if (cmd_t'(cmd_reg) == CMD_DIV)
                    begin
                        op       = DP_MM_AP;
                        ret_next = S_RES_R;
                    end
                    else
                        op = DP_RES_FROM_PROD;
                end
                else if (status.e_lsb)
                begin
                    op       = DP_MM_PB;
                    ret_next = S_PW_MULD;
                end
            end
            S_PW_MULD:  op = DP_PROD_FROM_R;
            S_PW_SQ:    op = DP_EXP_SHIFT;
            S_PW_SQC:
                // skip the square once the exponent runs out
                if (!status.e_zero)
                begin
                    op       = DP_MM_BB;
                    ret_next = S_PW_SQD;
                end
            S_PW_SQD:   op = DP_BASE_FROM_R;
            S_MM_T:     op = DP_MUL_T;
            S_MM_TW:
                if (!status.mul_busy)
                    op = DP_MUL_Q;
            S_MM_QW:
                if (!status.mul_busy)
                    op = DP_MUL_P;
            S_MM_PW:
                if (!status.mul_busy)
                    op = DP_REDC_FIN;
            S_RES_R:    op = DP_RES_FROM_R;
            S_OUT_FIN:  op = DP_RES_OUT;
            S_DONE:
                if (!out_valid_reg || !out_stall)
                begin
                    op             = DP_PUBLISH;
                    out_valid_next = 1'b1;
                end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

@@ hw/rtl/montgomery_modular_alu.sv @@
// Top level of the Montgomery modular ALU (R = 2^64, modulus below 2^62).
// Joins mma_ctrl and mma_dp; uses mma_pkg.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_stall  | cmd, operand_a, operand_b, integer_in, exponent
//  out     | out_valid/ out_stall | result
//  cfg     | cfg_write            | cfg_index, cfg_data
//
// One Montgomery multiply is three passes of the 64x64 multiplier, in turn.
// Convert in of a zero integer skips the remainder unit and the multiply.
// Pow and inv run one multiply per set bit of the reduced exponent and one
// square per bit but the highest; div adds a final multiply.
// A new transaction is taken only in idle; a finished result waits in the
// output register while the next transaction is taken. No clearing after reset.
`default_nettype none
module montgomery_modular_alu (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [3:0]                      cmd,
    input  wire logic [mma_pkg::VAL_W-1:0]       operand_a,
    input  wire logic [mma_pkg::VAL_W-1:0]       operand_b,
    input  wire logic signed [mma_pkg::WORD_W-1:0] integer_in,
    input  wire logic signed [mma_pkg::WORD_W-1:0] exponent,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [mma_pkg::VAL_W-1:0]            result,
    input  wire logic                            cfg_write,
    input  wire logic [mma_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [mma_pkg::WORD_W-1:0]      cfg_data
);
    import mma_pkg::*;

    dp_op_t     op;
    dp_status_t status;

    mma_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .op        (op)
    );

    mma_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .status     (status),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .operand_a  (operand_a),
        .operand_b  (operand_b),
        .integer_in (integer_in),
        .exponent   (exponent),
        .result     (result)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("block took a transaction and stayed idle");

    a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
        !(status.mul_busy && status.div_busy))
        else $error("multiplier and remainder unit busy together");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> (!status.mul_busy && !status.div_busy))
        else $error("arithmetic unit busy while idle");

endmodule
`default_nettype wire
